### design/u2mr_pkg.sv
package u2mr_pkg;

    localparam logic [7:0] QMARK      = 8'h3F;
    localparam logic [7:0] ROMAN_BASE = 8'h80;
    localparam int         MAP_DEPTH  = 128;
    localparam int         MAX_RES    = 3;
    localparam int         HELD_DEPTH = 3;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    localparam logic [2:0] LEN_BAD = 3'd0;
    localparam logic [2:0] LEN_1   = 3'd1;
    localparam logic [2:0] LEN_2   = 3'd2;
    localparam logic [2:0] LEN_3   = 3'd3;
    localparam logic [2:0] LEN_4   = 3'd4;

    typedef logic [20:0] cp_t;

    typedef struct packed {
        logic [7:0] roman_byte;
        logic       was_replaced;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0] r;
        logic [1:0]         cnt;
    } group_t;

    localparam res_t RES_REPL = '{roman_byte: QMARK, was_replaced: 1'b1};

    localparam logic [15:0] UPPER_CP [MAP_DEPTH] = '{
        16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
        16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
        16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
        16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
        16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
        16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
        16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
        16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
        16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
        16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
        16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
        16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
        16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
        16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
        16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
        16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0)
            len = LEN_1;
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
            len = LEN_2;
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
            len = LEN_3;
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
            len = LEN_4;
        else
            len = LEN_BAD;
        return len;
    endfunction

    function automatic res_t map_cp(input cp_t cp);
        res_t res;
        res = RES_REPL;
        if (cp[20:7] == '0)
        begin
            res.roman_byte   = cp[7:0];
            res.was_replaced = 1'b0;
        end
        else
        begin
            for (int i = 0; i < MAP_DEPTH; i++)
            begin
                if (cp == {5'b0, UPPER_CP[i]})
                begin
                    res.roman_byte   = 8'(ROMAN_BASE + 8'(i));
                    res.was_replaced = 1'b0;
                end
            end
        end
        return res;
    endfunction

    function automatic res_t single_res(input logic [7:0] b);
        res_t res;
        res = RES_REPL;
        if (lead_len(b) == LEN_1)
        begin
            res.roman_byte   = b;
            res.was_replaced = 1'b0;
        end
        return res;
    endfunction

endpackage

### design/utf8_to_macroman_decoder.sv
// channel | dir | tdata             | tuser        | tlast
// s_      | in  | [7:0] utf8_byte   | -            | stream_end
// m_      | out | [7:0] roman_byte  | was_replaced | run_last
//
// one input beat per cycle while s_tready is high; decode and reverse map
// sit between the held-byte state and the result register, results show in
// the next cycle; a beat giving n results queues them in turn (n up to 3,
// only at stream end); input stalls while two or more results are queued,
// or while one is queued and m_tready is low
// async active-low reset clears the held-byte count and the result queue
module utf8_to_macroman_decoder
    import u2mr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] utf8_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] roman_byte
    output logic       m_tuser,   // [0] was_replaced
    output logic       m_tlast
);

    group_t grp;
    logic   accept;
    logic   load_ok;

    assign s_tready = load_ok;
    assign accept   = s_tvalid && load_ok;

    u2mr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .utf8_byte  (s_tdata),
        .stream_end (s_tlast),
        .grp        (grp)
    );

    u2mr_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .grp      (grp),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### design/u2mr_core.sv
module u2mr_core
    import u2mr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] utf8_byte,
    input  logic       stream_end,
    output group_t     grp
);

    logic [7:0] held_reg  [HELD_DEPTH];
    logic [7:0] held_next [HELD_DEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] seq_reg, seq_next;

    logic [2:0] len_b;
    logic [2:0] len_f1;
    cp_t        cp_seq;
    cp_t        cp_flush;
    res_t       r0;
    logic       n0;
    res_t       fr [MAX_RES];
    logic [1:0] fn;

    always_comb
    begin
        unique case (seq_reg)
            LEN_2:   cp_seq = {10'b0, held_reg[0][4:0], utf8_byte[5:0]};
            LEN_3:   cp_seq = {5'b0, held_reg[0][3:0], held_reg[1][5:0], utf8_byte[5:0]};
            default: cp_seq = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0],
                               utf8_byte[5:0]};
        endcase
    end

    // normal step
    always_comb
    begin
        len_b     = lead_len(utf8_byte);
        held_next = held_reg;
        cnt_next  = cnt_reg;
        seq_next  = seq_reg;
        n0        = 1'b0;
        r0        = RES_REPL;
        if (cnt_reg == 2'd0)
        begin
            if (len_b <= LEN_1)
            begin
                n0 = 1'b1;
                r0 = single_res(utf8_byte);
            end
            else
            begin
                held_next[0] = utf8_byte;
                cnt_next     = 2'd1;
                seq_next     = len_b;
            end
        end
        else if ((3'(cnt_reg) + 3'd1) >= seq_reg)
        begin
            n0       = 1'b1;
            r0       = map_cp(cp_seq);
            cnt_next = 2'd0;
            seq_next = LEN_BAD;
        end
        else
        begin
            held_next[cnt_reg] = utf8_byte;
            cnt_next           = 2'(cnt_reg + 2'd1);
        end
    end

    // end-of-stream flush of the held bytes
    always_comb
    begin
        len_f1   = lead_len(held_next[1]);
        cp_flush = {10'b0, held_next[1][4:0], held_next[2][5:0]};
        fr[0]    = RES_REPL;
        fr[1]    = RES_REPL;
        fr[2]    = RES_REPL;
        fn       = cnt_next;
        if (cnt_next >= 2'd2)
        begin
            if (len_f1 == LEN_1)
            begin
                fr[1] = single_res(held_next[1]);
                if (cnt_next == 2'd3)
                    fr[2] = single_res(held_next[2]);
            end
            else if (len_f1 == LEN_2 && cnt_next == 2'd3)
            begin
                fr[1] = map_cp(cp_flush);
                fn    = 2'd2;
            end
            else if (cnt_next == 2'd3)
            begin
                fr[2] = single_res(held_next[2]);
            end
        end
    end

    always_comb
    begin
        grp = '0;
        if (n0)
        begin
            grp.r[0] = r0;
            grp.cnt  = 2'd1;
        end
        else if (stream_end)
        begin
            grp.r[0] = fr[0];
            grp.r[1] = fr[1];
            grp.r[2] = fr[2];
            grp.cnt  = fn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            seq_reg <= LEN_BAD;
        end
        else if (accept)
        begin
            if (stream_end)
            begin
                cnt_reg <= 2'd0;
                seq_reg <= LEN_BAD;
            end
            else
            begin
                cnt_reg <= cnt_next;
                seq_reg <= seq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

endmodule

### design/u2mr_outq.sv
module u2mr_outq
    import u2mr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  group_t     grp,
    output logic       load_ok,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tuser,
    output logic       m_tlast
);

    res_t       res_reg [MAX_RES];
    logic [1:0] left_reg;
    logic       load;
    logic       take;

    assign m_tvalid = (left_reg != 2'd0);
    assign take     = m_tvalid && m_tready;
    assign load_ok  = (left_reg == 2'd0) || (left_reg == 2'd1 && m_tready);
    assign load     = accept && (grp.cnt != 2'd0);
    assign m_tdata  = res_reg[0].roman_byte;
    assign m_tuser  = res_reg[0].was_replaced;
    assign m_tlast  = (left_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= 2'd0;
        else if (load)
            left_reg <= grp.cnt;
        else if (take)
            left_reg <= 2'(left_reg - 2'd1);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg[0] <= grp.r[0];
            res_reg[1] <= grp.r[1];
            res_reg[2] <= grp.r[2];
        end
        else if (take)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

endmodule
